// File: sv/uvarint_length_prefix_deframer_macros.svh
// Assertion macros for the length-prefix deframer.
`ifndef UVARINT_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define UVARINT_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ULPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define ULPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

// File: sv/ulpd_pkg.sv
// Types and constants shared by the length-prefix deframer modules.
package ulpd_pkg;

   localparam logic [3:0] MAX_PREFIX_BYTES = 4'd10;

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DROP    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_OVERFLOW = 2'd2,
      KIND_TRUNC    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    kind;
      logic        record_end;
      logic [63:0] record_length;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] count;
   } status_type;

endpackage

// File: sv/ulpd_in_reg.sv
// Input register: holds one incoming word until the decoder takes it.
module ulpd_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [7:0]       req_in_byte,
   input  logic             req_buffer_end,
   input  logic             advance,
   output logic             in_valid,
   output ulpd_pkg::req_type in_word
);

   logic              valid_ff;
   logic              valid_in;
   ulpd_pkg::req_type word_ff;
   logic              load;

   assign load     = !valid_ff || advance;
   assign valid_in = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         word_ff.data       <= req_in_byte;
         word_ff.buffer_end <= req_buffer_end;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

// File: sv/ulpd_core.sv
// Decoder state and the per-word prefix and payload logic.
module ulpd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ulpd_pkg::req_type    in_word,
   output logic                 res_valid,
   output ulpd_pkg::rsp_type    res,
   output ulpd_pkg::status_type status
);

   ulpd_pkg::phase_type phase_ff, phase_in;
   logic [63:0]         acc_ff, acc_in;
   logic [3:0]          count_ff, count_in;
   logic [63:0]         rem_ff, rem_in;

   logic        cont;
   logic        last;
   logic [6:0]  shift_amt;
   logic [63:0] grp;
   logic [63:0] len_new;
   logic        ovf;
   logic [63:0] rem_dec;
   logic        rem_zero;

   assign cont      = in_word.data[7];
   assign last      = in_word.buffer_end;
   // 7 * count as shift and subtract
   assign shift_amt = {count_ff, 3'b000} - {3'b000, count_ff};
   assign grp       = 64'(in_word.data[6:0]) << shift_amt;
   assign len_new   = acc_ff | grp;
   assign ovf       = (count_ff >= ulpd_pkg::MAX_PREFIX_BYTES) ||
                      (!cont && (count_ff == ulpd_pkg::MAX_PREFIX_BYTES - 4'd1) &&
                       (in_word.data > 8'd1));
   assign rem_dec   = rem_ff - 64'd1;
   assign rem_zero  = (rem_dec == 64'd0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            ulpd_pkg::PH_PREFIX: begin
               priority if (ovf) begin
                  phase_in = ulpd_pkg::PH_DROP;
               end else if (!cont && (len_new != 64'd0) && !last) begin
                  phase_in = ulpd_pkg::PH_PAYLOAD;
               end else begin
                  phase_in = ulpd_pkg::PH_PREFIX;
               end
            end
            ulpd_pkg::PH_PAYLOAD: begin
               if (rem_zero) begin
                  phase_in = ulpd_pkg::PH_PREFIX;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         // a buffer end always restarts on a fresh prefix
         if (last) begin
            phase_in = ulpd_pkg::PH_PREFIX;
         end
      end
   end

   // datapath and result
   always_comb begin
      acc_in            = acc_ff;
      count_in          = count_ff;
      rem_in            = rem_ff;
      res_valid         = 1'b0;
      res.out_byte      = 8'd0;
      res.kind          = ulpd_pkg::KIND_PAYLOAD;
      res.record_end    = 1'b0;
      res.record_length = 64'd0;
      if (step) begin
         unique case (phase_ff)
            ulpd_pkg::PH_PREFIX: begin
               priority if (ovf) begin
                  res_valid      = 1'b1;
                  res.kind       = ulpd_pkg::KIND_OVERFLOW;
                  res.record_end = 1'b1;
               end else if (!cont) begin
                  priority if (len_new == 64'd0) begin
                     res_valid      = 1'b1;
                     res.kind       = ulpd_pkg::KIND_EMPTY;
                     res.record_end = 1'b1;
                     acc_in         = 64'd0;
                     count_in       = 4'd0;
                     rem_in         = 64'd0;
                  end else if (last) begin
                     res_valid         = 1'b1;
                     res.kind          = ulpd_pkg::KIND_TRUNC;
                     res.record_end    = 1'b1;
                     res.record_length = len_new;
                  end else begin
                     acc_in   = len_new;
                     count_in = 4'd0;
                     rem_in   = len_new;
                  end
               end else begin
                  acc_in   = len_new;
                  count_in = count_ff + 4'd1;
                  if (last) begin
                     res_valid      = 1'b1;
                     res.kind       = ulpd_pkg::KIND_TRUNC;
                     res.record_end = 1'b1;
                  end
               end
            end
            ulpd_pkg::PH_PAYLOAD: begin
               rem_in            = rem_dec;
               res_valid         = 1'b1;
               res.out_byte      = in_word.data;
               res.record_length = acc_ff;
               priority if (rem_zero) begin
                  res.record_end = 1'b1;
                  acc_in         = 64'd0;
                  count_in       = 4'd0;
                  rem_in         = 64'd0;
               end else if (last) begin
                  res.kind       = ulpd_pkg::KIND_TRUNC;
                  res.record_end = 1'b1;
               end else begin
                  res.record_end = 1'b0;
               end
            end
            default: begin
               // drop: nothing to emit
               res_valid = 1'b0;
            end
         endcase
         if (last) begin
            acc_in   = 64'd0;
            count_in = 4'd0;
            rem_in   = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ulpd_pkg::PH_PREFIX;
         acc_ff   <= 64'd0;
         count_ff <= 4'd0;
         rem_ff   <= 64'd0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
      end
   end

   assign status.phase = phase_ff;
   assign status.count = count_ff;

endmodule

// File: sv/ulpd_out_reg.sv
// Result register: holds one outgoing word until the receiver takes it.
module ulpd_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              res_valid,
   input  ulpd_pkg::rsp_type res,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output ulpd_pkg::rsp_type rsp_word
);

   logic              valid_ff;
   logic              valid_in;
   ulpd_pkg::rsp_type word_ff;

   always_comb begin
      priority if (advance) begin
         valid_in = res_valid;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         word_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: sv/uvarint_length_prefix_deframer.sv
// Top level of the LEB128 length-prefix record deframer.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_in_byte, req_buffer_end
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_out_byte, rsp_kind,
//           |           |                        | rsp_record_end, rsp_record_length
//
// One word is taken per cycle unless rsp_stall backs the block up; a taken word goes
// through the input register, then is decoded into the result register.
// The prefix shift-or and its 64-bit zero test set the decode path; the
// remaining-count decrement and its zero compare run beside it.
// Reset is synchronous and returns the decoder to the prefix phase at once.
// rsp_stall holds the result register and, through it, the input register.
`include "uvarint_length_prefix_deframer_macros.svh"

module uvarint_length_prefix_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic        rsp_record_end,
   output logic [63:0] rsp_record_length
);

   logic                 in_valid;
   ulpd_pkg::req_type    in_word;
   logic                 advance;
   logic                 res_valid;
   ulpd_pkg::rsp_type    res;
   ulpd_pkg::rsp_type    rsp_word;
   ulpd_pkg::status_type status;
   logic                 end_taken;
   logic                 ovf_taken;
   logic                 prefix_fresh;
   logic                 error_out;

   // decode whenever the result register is free or being emptied
   assign advance   = in_valid && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid && !advance;

   ulpd_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_in_byte    (req_in_byte),
      .req_buffer_end (req_buffer_end),
      .advance        (advance),
      .in_valid       (in_valid),
      .in_word        (in_word)
   );

   ulpd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_word   (in_word),
      .res_valid (res_valid),
      .res       (res),
      .status    (status)
   );

   ulpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_byte      = rsp_word.out_byte;
   assign rsp_kind          = rsp_word.kind;
   assign rsp_record_end    = rsp_word.record_end;
   assign rsp_record_length = rsp_word.record_length;

   assign end_taken    = advance && in_word.buffer_end;
   assign ovf_taken    = advance && res_valid && (res.kind == ulpd_pkg::KIND_OVERFLOW) &&
                         !in_word.buffer_end;
   assign prefix_fresh = (status.phase == ulpd_pkg::PH_PREFIX) && (status.count == 4'd0);
   assign error_out    = rsp_valid && (rsp_kind != ulpd_pkg::KIND_PAYLOAD);

   `ULPD_ASSERT_NEXT(a_end_restarts, clock, reset, end_taken, prefix_fresh)
   `ULPD_ASSERT_NEXT(a_ovf_drops, clock, reset, ovf_taken, status.phase == ulpd_pkg::PH_DROP)
   `ULPD_ASSERT_NOW(a_error_ends, clock, reset, error_out, rsp_record_end)

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the LEB128 length-prefix record deframer.
`timescale 1ns / 1ps

module tb_top;

   localparam int PLAN_WORDS   = 1750;
   localparam int CALM_WORDS   = 250;
   localparam int PRESSURE_AT  = 400;
   localparam int PRESSURE_RUN = 40;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PRINT_CAP    = 40;

   // Tracks the deframer state word by word and holds the results still due.
   class record_checker;
      ulpd_pkg::phase_type stage;
      logic [63:0]         length_sum;
      logic [3:0]          groups_seen;
      logic [63:0]         payload_left;
      ulpd_pkg::rsp_type   due_results[$];
      int                  mismatch_count;

      function new();
         mismatch_count = 0;
         start_prefix();
      endfunction

      function void start_prefix();
         stage        = ulpd_pkg::PH_PREFIX;
         length_sum   = '0;
         groups_seen  = '0;
         payload_left = '0;
      endfunction

      function void note_word(input logic [7:0] b, input logic last);
         ulpd_pkg::rsp_type r;
         logic [63:0]       len;
         bit                emit;
         r            = '0;
         r.record_end = 1'b1;
         emit         = 1'b0;
         case (stage)
            ulpd_pkg::PH_PREFIX: begin
               if (groups_seen >= ulpd_pkg::MAX_PREFIX_BYTES) begin
                  // eleventh prefix byte: overflow whatever its value
                  r.kind = ulpd_pkg::KIND_OVERFLOW;
                  emit   = 1'b1;
                  stage  = ulpd_pkg::PH_DROP;
               end else if (!b[7]) begin
                  if (groups_seen == ulpd_pkg::MAX_PREFIX_BYTES - 4'd1 && b > 8'd1) begin
                     r.kind = ulpd_pkg::KIND_OVERFLOW;
                     emit   = 1'b1;
                     stage  = ulpd_pkg::PH_DROP;
                  end else begin
                     len = length_sum | (64'(b) << (7 * groups_seen));
                     if (len == '0) begin
                        r.kind = ulpd_pkg::KIND_EMPTY;
                        emit   = 1'b1;
                        start_prefix();
                     end else if (last) begin
                        r.kind          = ulpd_pkg::KIND_TRUNC;
                        r.record_length = len;
                        emit            = 1'b1;
                     end else begin
                        stage        = ulpd_pkg::PH_PAYLOAD;
                        length_sum   = len;
                        groups_seen  = '0;
                        payload_left = len;
                     end
                  end
               end else begin
                  length_sum  |= 64'(b[6:0]) << (7 * groups_seen);
                  groups_seen += 4'd1;
                  if (last) begin
                     r.kind = ulpd_pkg::KIND_TRUNC;
                     emit   = 1'b1;
                  end
               end
            end
            ulpd_pkg::PH_PAYLOAD: begin
               payload_left    -= 64'd1;
               r.out_byte      = b;
               r.record_length = length_sum;
               emit            = 1'b1;
               if (payload_left == '0) begin
                  r.kind = ulpd_pkg::KIND_PAYLOAD;
                  start_prefix();
               end else if (last) begin
                  r.kind = ulpd_pkg::KIND_TRUNC;
               end else begin
                  r.kind       = ulpd_pkg::KIND_PAYLOAD;
                  r.record_end = 1'b0;
               end
            end
            default: ;
         endcase
         // a buffer end always restarts the prefix
         if (last) start_prefix();
         if (emit) due_results.insert(due_results.size(), r);
      endfunction

      task report_mismatch(input string what);
         mismatch_count++;
         if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_result(input logic [7:0] ob, input logic [1:0] k, input logic re,
                        input logic [63:0] rl);
         ulpd_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result with none due: kind %0d byte %02h", k, ob));
         end else begin
            want = due_results.pop_front();
            if (k !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", k, want.kind));
            if (ob !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
            if (re !== want.record_end)
               report_mismatch($sformatf("record_end %0b, want %0b", re, want.record_end));
            if (rl !== want.record_length)
               report_mismatch($sformatf("record_length %0h, want %0h", rl,
                                         want.record_length));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = '0;
   logic        req_buffer_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_kind;
   logic        rsp_record_end;
   logic [63:0] rsp_record_length;

   record_checker     board = new();
   ulpd_pkg::req_type word_plan[$];
   int                words_noted = 0;

   uvarint_length_prefix_deframer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_buffer_end    (req_buffer_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_kind          (rsp_kind),
      .rsp_record_end    (rsp_record_end),
      .rsp_record_length (rsp_record_length)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void add_word(input logic [7:0] d, input logic e);
      word_plan.insert(word_plan.size(), ulpd_pkg::req_type'({d, e}));
   endfunction

   // Append one record, mostly well formed, else an overflow, a cut prefix or noise.
   function automatic void add_random_record();
      ulpd_pkg::req_type rec[$];
      logic [63:0]       len;
      logic [63:0]       rest;
      int                pick;
      int                pad;
      int                cut;
      int                noise_tail;
      bit                close;
      noise_tail = 0;
      close      = 1'b1;
      pick       = $urandom_range(0, 99);
      if (pick < 60) begin
         close = 1'b0;
         pad   = $urandom_range(0, 99);
         if (pad < 10) len = '0;
         else if (pad < 70) len = $urandom_range(1, 8);
         else if (pad < 92) len = $urandom_range(9, 40);
         else len = $urandom_range(100, 200);
         rest = len;
         do begin
            rec.insert(rec.size(), ulpd_pkg::req_type'({rest > 64'd127, rest[6:0], 1'b0}));
            rest = rest >> 7;
         end while (rest != '0);
         // occasionally stretch the prefix with zero groups
         if ($urandom_range(0, 9) == 0) begin
            pad = $urandom_range(1, 3);
            rec[rec.size() - 1].data[7] = 1'b1;
            repeat (pad - 1) rec.insert(rec.size(), ulpd_pkg::req_type'({8'h80, 1'b0}));
            rec.insert(rec.size(), ulpd_pkg::req_type'({8'h00, 1'b0}));
         end
         repeat (len)
            rec.insert(rec.size(),
                       ulpd_pkg::req_type'({8'($urandom_range(0, 255)), 1'b0}));
         cut = $urandom_range(0, 9);
         if (cut == 0) begin
            cut = $urandom_range(0, rec.size() - 1);
            rec = rec[0:cut];
            rec[cut].buffer_end = 1'b1;
         end else if (cut < 4) begin
            rec[rec.size() - 1].buffer_end = 1'b1;
         end
      end else if (pick < 72) begin
         repeat (9)
            rec.insert(rec.size(),
                       ulpd_pkg::req_type'({1'b1, 7'($urandom_range(0, 127)), 1'b0}));
         if ($urandom_range(0, 3) == 0)
            rec.insert(rec.size(), ulpd_pkg::req_type'({8'($urandom_range(0, 1)), 1'b0}));
         else
            rec.insert(rec.size(),
                       ulpd_pkg::req_type'({8'($urandom_range(2, 127)), 1'b0}));
         noise_tail = $urandom_range(0, 5);
      end else if (pick < 80) begin
         repeat (10)
            rec.insert(rec.size(),
                       ulpd_pkg::req_type'({1'b1, 7'($urandom_range(0, 127)), 1'b0}));
         noise_tail = $urandom_range(1, 6);
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 9))
            rec.insert(rec.size(),
                       ulpd_pkg::req_type'({1'b1, 7'($urandom_range(0, 127)), 1'b0}));
      end else begin
         noise_tail = $urandom_range(1, 12);
      end
      repeat (noise_tail)
         rec.insert(rec.size(), ulpd_pkg::req_type'({8'($urandom_range(0, 255)), 1'b0}));
      if (close) rec[rec.size() - 1].buffer_end = 1'b1;
      foreach (rec[k]) word_plan.insert(word_plan.size(), rec[k]);
   endfunction

   // Offer one word and hold it until taken.
   task automatic send_word(input ulpd_pkg::req_type w);
      req_valid      <= 1'b1;
      req_in_byte    <= w.data;
      req_buffer_end <= w.buffer_end;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      board.note_word(w.data, w.buffer_end);
      words_noted++;
      @(posedge clock);
   endtask

   initial begin
      add_word(8'h00, 1'b0);                      // empty record
      add_word(8'h01, 1'b0);
      add_word(8'hFF, 1'b0);                      // one-byte record
      add_word(8'h85, 1'b1);                      // buffer end inside the prefix
      add_word(8'h05, 1'b1);                      // buffer end right after the prefix
      repeat (9) add_word(8'hFF, 1'b0);
      add_word(8'h01, 1'b0);                      // tenth byte of 1: full 64-bit length
      add_word(8'hA5, 1'b1);                      // cut inside the payload
      repeat (9) add_word(8'h80, 1'b0);
      add_word(8'h02, 1'b0);                      // tenth byte above 1: overflow
      add_word(8'h7E, 1'b1);                      // dropped up to the buffer end
      while (word_plan.size() < PLAN_WORDS) add_random_record();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (word_plan[k]) begin
         if (k < word_plan.size() - CALM_WORDS &&
             !(k >= PRESSURE_AT && k < PRESSURE_AT + PRESSURE_RUN) &&
             $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         send_word(word_plan[k]);
      end
      req_valid <= 1'b0;

      while (board.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // Receiver: random stall bursts, one long hold to back the block up, calm at the end.
   initial begin
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && words_noted >= PRESSURE_AT) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (words_noted < word_plan.size() - CALM_WORDS &&
                      $urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sample mid-cycle: the values hold until the accepting edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_out_byte, rsp_kind, rsp_record_end, rsp_record_length);
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/ulpd_pkg.sv
sv/ulpd_in_reg.sv
sv/ulpd_core.sv
sv/ulpd_out_reg.sv
sv/uvarint_length_prefix_deframer.sv
sim/tb_top.sv
